@@ sv/lfr_pkg.sv @@
// Package for the LRU frame replacer: sizes, codes and controller/datapath bundles.
package lfr_pkg;

	localparam int FRAMES  = 64;
	localparam int FRAME_W = 6;
	localparam int LINK_W  = $clog2(FRAMES + 1);
	localparam int COUNT_W = 7;
	localparam int DEPTH   = FRAMES + 1;
	localparam logic [LINK_W-1:0] SENTINEL = LINK_W'(FRAMES);

	// request kinds as carried on s_tuser; the fourth code is unused
	localparam logic [1:0] KIND_VICTIM = 2'd0;
	localparam logic [1:0] KIND_PIN    = 2'd1;
	localparam logic [1:0] KIND_UNPIN  = 2'd2;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOCHANGE = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_VLINKS,
		S_CLEAR,
		S_HEAD,
		S_LINKF,
		S_FIN
	} state_t;

	// read address source for both link tables
	typedef enum logic [1:0] {
		RA_FRAME,
		RA_SENT,
		RA_PREV
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_UNLINK,
		WR_CLEAR,
		WR_SELF,
		WR_HEADLINK
	} wr_op_t;

	typedef struct packed {
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    tgt_load_in;
		logic    tgt_load_prev;
		wr_op_t  wr_op;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    out_load;
		logic    victim;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic is_member;
		logic count_zero;
		logic frame_bad;
		logic out_free;
	} sts_t;

endpackage

@@ sv/lfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/lfr_datapath.sv @@
// Datapath: link tables with valid bits, target frame, member count and result register.
module lfr_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lfr_pkg::cmd_t                cmd,
	output lfr_pkg::sts_t                sts,
	input  logic [lfr_pkg::FRAME_W-1:0]  frame_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output lfr_pkg::status_t             out_status,
	output logic [lfr_pkg::FRAME_W-1:0]  out_victim,
	output logic [lfr_pkg::COUNT_W-1:0]  out_count
);
	import lfr_pkg::*;

	logic [LINK_W-1:0]  target_q;
	logic [LINK_W-1:0]  raddr;
	logic [LINK_W-1:0]  raddr_q;
	logic [LINK_W-1:0]  next_ram_rd, prev_ram_rd;
	logic [LINK_W-1:0]  next_rd, prev_rd;
	logic               next_vrd_q, prev_vrd_q;
	logic [FRAMES:0]    next_vld_q, prev_vld_q;
	logic               next_we, prev_we;
	logic [LINK_W-1:0]  next_waddr, next_wdata, prev_waddr, prev_wdata;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [FRAME_W-1:0] out_victim_q;
	logic [COUNT_W-1:0] out_count_q;

	// never-written entries read as their own index (self link)
	assign next_rd = next_vrd_q ? next_ram_rd : raddr_q;
	assign prev_rd = prev_vrd_q ? prev_ram_rd : raddr_q;

	always_comb begin
		case (cmd.rd_sel)
			RA_FRAME: raddr = LINK_W'(frame_in);
			RA_SENT:  raddr = SENTINEL;
			RA_PREV:  raddr = prev_rd;
			default:  raddr = SENTINEL;
		endcase
	end

	always_comb begin
		next_we    = 1'b0;
		prev_we    = 1'b0;
		next_waddr = target_q;
		next_wdata = target_q;
		prev_waddr = target_q;
		prev_wdata = target_q;
		case (cmd.wr_op)
			WR_UNLINK: begin
				next_we    = 1'b1;
				prev_we    = 1'b1;
				next_waddr = prev_rd;
				next_wdata = next_rd;
				prev_waddr = next_rd;
				prev_wdata = prev_rd;
			end
			WR_CLEAR: begin
				next_we = 1'b1;
				prev_we = 1'b1;
			end
			WR_SELF: begin
				next_we    = 1'b1;
				prev_we    = 1'b1;
				next_wdata = next_rd;
				prev_wdata = SENTINEL;
			end
			WR_HEADLINK: begin
				next_we    = 1'b1;
				prev_we    = 1'b1;
				next_waddr = SENTINEL;
				prev_waddr = next_rd;
			end
			default: begin
				next_we = 1'b0;
				prev_we = 1'b0;
			end
		endcase
	end

	lfr_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (next_ram_rd)
	);

	lfr_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (prev_ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_vld_q <= '0;
			prev_vld_q <= '0;
			count_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (next_we) begin
				next_vld_q[next_waddr] <= 1'b1;
			end
			if (prev_we) begin
				prev_vld_q[prev_waddr] <= 1'b1;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - COUNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			raddr_q    <= raddr;
			next_vrd_q <= next_vld_q[raddr];
			prev_vrd_q <= prev_vld_q[raddr];
		end
		if (cmd.tgt_load_in) begin
			target_q <= LINK_W'(frame_in);
		end else if (cmd.tgt_load_prev) begin
			target_q <= prev_rd;
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.status;
			out_victim_q <= (cmd.victim && cmd.status == ST_DONE) ?
				target_q[FRAME_W-1:0] : '0;
			out_count_q  <= count_q;
		end
	end

	assign sts.is_member  = (next_rd != target_q);
	assign sts.count_zero = (count_q == '0);
	assign sts.frame_bad  = (target_q >= LINK_W'(FRAMES));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_victim = out_victim_q;
	assign out_count  = out_count_q;

endmodule

@@ sv/lfr_ctrl.sv @@
// Controller: sequences link table reads and writes for one request at a time.
module lfr_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              kind_in,
	input  lfr_pkg::sts_t           sts,
	output lfr_pkg::cmd_t           cmd
);
	import lfr_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] kind_q;
	status_t    status_q, status_d;
	logic       status_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind_in;
		end
		if (status_set) begin
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		status_set = 1'b0;
		status_d   = ST_NOCHANGE;
		cmd        = '0;
		cmd.rd_sel = RA_FRAME;
		cmd.wr_op  = WR_NONE;
		cmd.status = status_q;
		cmd.victim = (kind_q == KIND_VICTIM);
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = (kind_in == KIND_VICTIM) ? RA_SENT : RA_FRAME;
				if (in_valid) begin
					cmd.tgt_load_in = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				status_set = 1'b1;
				state_d    = S_FIN;
				case (kind_q)
					KIND_VICTIM: begin
						if (sts.count_zero) begin
							status_d = ST_EMPTY;
						end else begin
							// tail is prev of sentinel; fetch its links
							cmd.tgt_load_prev = 1'b1;
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_PREV;
							state_d    = S_VLINKS;
						end
					end
					KIND_PIN: begin
						if (sts.frame_bad) begin
							status_d = ST_RANGE;
						end else if (sts.is_member) begin
							cmd.wr_op = WR_UNLINK;
							state_d   = S_CLEAR;
						end
					end
					KIND_UNPIN: begin
						if (sts.frame_bad) begin
							status_d = ST_RANGE;
						end else if (!sts.is_member) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_SENT;
							state_d    = S_HEAD;
						end
					end
					default: begin
						status_d = ST_NOCHANGE;
					end
				endcase
			end
			S_VLINKS: begin
				cmd.wr_op = WR_UNLINK;
				state_d   = S_CLEAR;
			end
			S_CLEAR: begin
				cmd.wr_op   = WR_CLEAR;
				cmd.cnt_dec = 1'b1;
				status_set  = 1'b1;
				status_d    = ST_DONE;
				state_d     = S_FIN;
			end
			S_HEAD: begin
				cmd.wr_op = WR_SELF;
				state_d   = S_LINKF;
			end
			S_LINKF: begin
				cmd.wr_op   = WR_HEADLINK;
				cmd.cnt_inc = 1'b1;
				status_set  = 1'b1;
				status_d    = ST_DONE;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/lru_frame_replacer_core.sv @@
// LRU frame replacer top level: request stream in, one result transfer per request out.
// Each request runs IDLE, EVAL and FIN; a pin that unlinks adds CLEAR, victim adds VLINKS and CLEAR,
// unpin of an absent frame adds HEAD and LINKF; empty, no-change, out of range or unused kind go to FIN.
// One request is handled at a time, paced by the single read and write port per
// link table; a new request is taken while the previous result waits on m_tready.
// Reset (arst_n low) empties the replacer at once: link entries read as self links via valid bits.
module lru_frame_replacer_core (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [5:0] frame, [7:6] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] victim_frame, [12:6] evictable_count, [15:13] zero
	output logic [1:0]  m_tuser    // [1:0] status
);
	import lfr_pkg::*;

	cmd_t               cmd;
	sts_t               sts;
	status_t            out_status;
	logic [FRAME_W-1:0] out_victim;
	logic [COUNT_W-1:0] out_count;

	// The controller walks each request through the link tables:
	//   pin:    read frame links, unlink neighbors, self-link frame
	//   victim: read sentinel prev (tail), read tail links, then as pin
	//   unpin:  read frame links, read head, link frame, patch head and sentinel
	lfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.kind_in  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath owns both link tables, the count and the result register
	lfr_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.frame_in   (s_tdata[FRAME_W-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_victim (out_victim),
		.out_count  (out_count)
	);

	// pack the result transfer
	assign m_tdata = {3'b000, out_count, out_victim};
	assign m_tuser = out_status;

endmodule

@@ sv/lfr_checker.sv @@
// Port-level checker for the LRU frame replacer, bound to the top level.
module lfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import lfr_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request in flight: ready drops after a request transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// count never exceeds the frame count
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[12:6] <= COUNT_W'(FRAMES))
		else $error("evictable count out of range");

	// empty report carries a zero count and no victim
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[12:6] == '0 && m_tdata[5:0] == '0)
		else $error("empty status with nonzero count or victim");

	// only a completed request can name a victim
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_DONE |-> m_tdata[5:0] == '0)
		else $error("victim reported on failed request");

endmodule

bind lru_frame_replacer_core lfr_checker u_lfr_checker (.*);
